>>> sv/baro_sensor_compensation_assert.svh
// Assertion macros for the barometric compensation block.
// Needs clock and reset in scope at the point of use.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

`define BSC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define BSC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bsc_pkg.sv
// Types and constants of the barometric compensation block.
// No dependencies.
package bsc_pkg;

   localparam int RawW     = 24;
   localparam int CoeffW   = 16;
   localparam int CsrIdxW  = 3;
   localparam int NumCoeff = 6;
   localparam int TempOutW = 19;
   localparam int PresOutW = 32;
   localparam int TempW    = 20;

   typedef logic [CsrIdxW-1:0] csr_idx_type;

   localparam csr_idx_type CsrPresSens  = 3'd0;
   localparam csr_idx_type CsrPresOff   = 3'd1;
   localparam csr_idx_type CsrSensTc    = 3'd2;
   localparam csr_idx_type CsrOffTc     = 3'd3;
   localparam csr_idx_type CsrTempRef   = 3'd4;
   localparam csr_idx_type CsrTempGain  = 3'd5;

   localparam logic signed [TempW-1:0] TempHigh = 20'sd2000;
   localparam logic signed [TempW-1:0] TempLow  = -20'sd1500;

   typedef struct packed {
      logic [RawW-1:0] raw_pressure;
      logic [RawW-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [TempOutW-1:0] temperature_centi;
      logic signed [PresOutW-1:0] pressure_centi;
   } rsp_type;

endpackage

>>> sv/baro_sensor_compensation.sv
// Barometric sensor second-order compensation, nine-stage pipeline.
// Depends on bsc_pkg and baro_sensor_compensation_assert.svh.
//
// Usage:
//   req_ carries one word: a raw pressure and a raw temperature conversion.
//   rsp_ returns one word per request: temperature in 0.01 C and pressure
//   in 0.01 mbar, the pressure saturated to 32 bits.
//   csr_ writes the six calibration coefficients by index 0..5; writes to
//   other indexes are dropped. csr_ready is always high. Write only while
//   no request is in flight.
//   A request is registered in stages 0 to 8 in order; rsp_valid is stage 8's.
//   Throughput: one word per cycle while rsp_stall is low; every stage holds one word and a
//   multiplier stage set the depth (four products, two squares, then the
//   pressure product split into two 24 by 20 partial products).
//   A stage advances when it is empty or the stage after it advances, so a
//   stalled result only blocks input once all nine stages are full.
//   Reset clears all stage valid bits and the coefficients to zero.
`include "baro_sensor_compensation_assert.svh"

module baro_sensor_compensation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bsc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bsc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  bsc_pkg::csr_idx_type                csr_index,
   input  logic [bsc_pkg::CoeffW-1:0]          csr_data
);

   localparam int NStg  = 9;
   localparam int DtW   = 25;
   localparam int ProdW = 42;
   localparam int SqW   = 50;
   localparam int T2W   = 18;
   localparam int SqTW  = 40;
   localparam int AdjW  = 44;
   localparam int OffW  = 40;
   localparam int SensW = 40;
   localparam int LoW   = 20;
   localparam int PloW  = 44;
   localparam int PhiW  = 45;
   localparam int FullW = 64;
   localparam int QW    = 45;
   localparam int ToutW = 21;

   localparam logic signed [QW-1:0] PresMax = QW'(64'sd2147483647);
   localparam logic signed [QW-1:0] PresMin = QW'(-64'sd2147483648);

   logic [bsc_pkg::CoeffW-1:0] coeff_ff [bsc_pkg::NumCoeff];

   logic [NStg-1:0] vld_ff, vld_in, adv;

   // stage 0
   logic [bsc_pkg::RawW-1:0] s0_d1_ff;
   logic signed [DtW-1:0]    s0_dt_ff, s0_dt_in;
   // stage 1
   logic [bsc_pkg::RawW-1:0] s1_d1_ff;
   logic signed [ProdW-1:0]  s1_dtc6_ff, s1_dtc6_in, s1_c4dt_ff, s1_c4dt_in;
   logic signed [ProdW-1:0]  s1_c3dt_ff, s1_c3dt_in;
   logic signed [SqW-1:0]    s1_dtsq_ff, s1_dtsq_in;
   // stage 2
   logic [bsc_pkg::RawW-1:0] s2_d1_ff;
   logic signed [bsc_pkg::TempW-1:0] s2_temp_ff, s2_temp_in;
   logic signed [OffW-1:0]   s2_off_ff, s2_off_in;
   logic signed [SensW-1:0]  s2_sens_ff, s2_sens_in;
   logic [T2W-1:0]           s2_t2_ff, s2_t2_in;
   // stage 3
   logic [bsc_pkg::RawW-1:0] s3_d1_ff;
   logic signed [bsc_pkg::TempW-1:0] s3_temp_ff, s3_tm, s3_tp;
   logic signed [OffW-1:0]   s3_off_ff;
   logic signed [SensW-1:0]  s3_sens_ff;
   logic [T2W-1:0]           s3_t2_ff;
   logic signed [SqTW-1:0]   s3_a_ff, s3_a_in, s3_b_ff, s3_b_in;
   logic                     s3_low_ff, s3_low_in, s3_cold_ff, s3_cold_in;
   // stage 4
   logic [bsc_pkg::RawW-1:0] s4_d1_ff;
   logic signed [bsc_pkg::TempW-1:0] s4_temp_ff;
   logic signed [OffW-1:0]   s4_off_ff;
   logic signed [SensW-1:0]  s4_sens_ff;
   logic [T2W-1:0]           s4_t2_ff, s4_t2_in;
   logic signed [AdjW-1:0]   s4_a5, s4_b7, s4_b11;
   logic signed [AdjW-1:0]   s4_off2_ff, s4_off2_in, s4_sens2_ff, s4_sens2_in;
   // stage 5
   logic [bsc_pkg::RawW-1:0] s5_d1_ff;
   logic signed [OffW-1:0]   s5_offd_ff, s5_offd_in;
   logic signed [SensW-1:0]  s5_sensd_ff, s5_sensd_in;
   logic signed [ToutW-1:0]  s5_tout_ff, s5_tout_in;
   // stage 6
   logic [PloW-1:0]          s6_plo_ff, s6_plo_in;
   logic signed [PhiW-1:0]   s6_phi_ff, s6_phi_in;
   logic signed [OffW-1:0]   s6_offd_ff;
   logic signed [ToutW-1:0]  s6_tout_ff;
   // stage 7
   logic signed [FullW-1:0]  s7_full_ff, s7_full_in;
   logic signed [OffW-1:0]   s7_offd_ff;
   logic signed [ToutW-1:0]  s7_tout_ff;
   // stage 8
   logic signed [QW-1:0]     s8_q, s8_p, s8_sat;
   bsc_pkg::rsp_type         s8_rsp_ff, s8_rsp_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bsc_pkg::NumCoeff; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsc_pkg::CsrPresSens: coeff_ff[bsc_pkg::CsrPresSens] <= csr_data;
            bsc_pkg::CsrPresOff:  coeff_ff[bsc_pkg::CsrPresOff]  <= csr_data;
            bsc_pkg::CsrSensTc:   coeff_ff[bsc_pkg::CsrSensTc]   <= csr_data;
            bsc_pkg::CsrOffTc:    coeff_ff[bsc_pkg::CsrOffTc]    <= csr_data;
            bsc_pkg::CsrTempRef:  coeff_ff[bsc_pkg::CsrTempRef]  <= csr_data;
            bsc_pkg::CsrTempGain: coeff_ff[bsc_pkg::CsrTempGain] <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   always_comb begin
      adv[NStg-1] = !vld_ff[NStg-1] || !rsp_stall;
      for (int i = NStg - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NStg; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[NStg-1];
   assign rsp_data  = s8_rsp_ff;

   // datapath
   always_comb begin
      s0_dt_in = $signed({1'b0, req_data.raw_temperature})
               - $signed({1'b0, coeff_ff[bsc_pkg::CsrTempRef], 8'h00});

      s1_dtc6_in = ProdW'(s0_dt_ff)
                 * ProdW'($signed({1'b0, coeff_ff[bsc_pkg::CsrTempGain]}));
      s1_c4dt_in = ProdW'(s0_dt_ff)
                 * ProdW'($signed({1'b0, coeff_ff[bsc_pkg::CsrOffTc]}));
      s1_c3dt_in = ProdW'(s0_dt_ff)
                 * ProdW'($signed({1'b0, coeff_ff[bsc_pkg::CsrSensTc]}));
      s1_dtsq_in = SqW'(s0_dt_ff) * SqW'(s0_dt_ff);

      s2_temp_in = bsc_pkg::TempW'(s1_dtc6_ff >>> 23) + bsc_pkg::TempHigh;
      s2_off_in  = OffW'($signed({1'b0, coeff_ff[bsc_pkg::CsrPresOff], 16'h0000}))
                 + OffW'(s1_c4dt_ff >>> 7);
      s2_sens_in = SensW'($signed({1'b0, coeff_ff[bsc_pkg::CsrPresSens], 15'h0000}))
                 + SensW'(s1_c3dt_ff >>> 8);
      s2_t2_in   = T2W'(s1_dtsq_ff >>> 31);

      s3_tm      = s2_temp_ff - bsc_pkg::TempHigh;
      s3_tp      = s2_temp_ff - bsc_pkg::TempLow;
      s3_a_in    = SqTW'(s3_tm) * SqTW'(s3_tm);
      s3_b_in    = SqTW'(s3_tp) * SqTW'(s3_tp);
      s3_low_in  = s2_temp_ff < bsc_pkg::TempHigh;
      s3_cold_in = s2_temp_ff < bsc_pkg::TempLow;

      s4_a5  = (AdjW'(s3_a_ff) <<< 2) + AdjW'(s3_a_ff);
      s4_b7  = (AdjW'(s3_b_ff) <<< 3) - AdjW'(s3_b_ff);
      s4_b11 = (AdjW'(s3_b_ff) <<< 3) + (AdjW'(s3_b_ff) <<< 1) + AdjW'(s3_b_ff);
      if (s3_low_ff) begin
         s4_off2_in  = (s4_a5 >>> 1) + (s3_cold_ff ? s4_b7 : '0);
         s4_sens2_in = (s4_a5 >>> 2) + (s3_cold_ff ? (s4_b11 >>> 1) : '0);
         s4_t2_in    = s3_t2_ff;
      end else begin
         s4_off2_in  = '0;
         s4_sens2_in = '0;
         s4_t2_in    = '0;
      end

      s5_offd_in  = s4_off_ff - OffW'(s4_off2_ff);
      s5_sensd_in = s4_sens_ff - SensW'(s4_sens2_ff);
      s5_tout_in  = ToutW'(s4_temp_ff) - ToutW'($signed({1'b0, s4_t2_ff}));

      s6_plo_in = PloW'(s5_d1_ff) * PloW'(s5_sensd_ff[LoW-1:0]);
      s6_phi_in = PhiW'($signed({1'b0, s5_d1_ff}))
                * PhiW'($signed(s5_sensd_ff[SensW-1:LoW]));

      s7_full_in = (FullW'(s6_phi_ff) <<< LoW) + FullW'($signed({1'b0, s6_plo_ff}));

      s8_q = QW'(s7_full_ff >>> 21) - QW'(s7_offd_ff);
      s8_p = s8_q >>> 15;
      if (s8_p > PresMax) begin
         s8_sat = PresMax;
      end else if (s8_p < PresMin) begin
         s8_sat = PresMin;
      end else begin
         s8_sat = s8_p;
      end
      s8_rsp_in.temperature_centi = bsc_pkg::TempOutW'(s7_tout_ff);
      s8_rsp_in.pressure_centi    = bsc_pkg::PresOutW'(s8_sat);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_d1_ff <= req_data.raw_pressure;
         s0_dt_ff <= s0_dt_in;
      end
      if (adv[1]) begin
         s1_d1_ff   <= s0_d1_ff;
         s1_dtc6_ff <= s1_dtc6_in;
         s1_c4dt_ff <= s1_c4dt_in;
         s1_c3dt_ff <= s1_c3dt_in;
         s1_dtsq_ff <= s1_dtsq_in;
      end
      if (adv[2]) begin
         s2_d1_ff   <= s1_d1_ff;
         s2_temp_ff <= s2_temp_in;
         s2_off_ff  <= s2_off_in;
         s2_sens_ff <= s2_sens_in;
         s2_t2_ff   <= s2_t2_in;
      end
      if (adv[3]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s2_temp_ff;
         s3_off_ff  <= s2_off_ff;
         s3_sens_ff <= s2_sens_ff;
         s3_t2_ff   <= s2_t2_ff;
         s3_a_ff    <= s3_a_in;
         s3_b_ff    <= s3_b_in;
         s3_low_ff  <= s3_low_in;
         s3_cold_ff <= s3_cold_in;
      end
      if (adv[4]) begin
         s4_d1_ff    <= s3_d1_ff;
         s4_temp_ff  <= s3_temp_ff;
         s4_off_ff   <= s3_off_ff;
         s4_sens_ff  <= s3_sens_ff;
         s4_t2_ff    <= s4_t2_in;
         s4_off2_ff  <= s4_off2_in;
         s4_sens2_ff <= s4_sens2_in;
      end
      if (adv[5]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_offd_ff  <= s5_offd_in;
         s5_sensd_ff <= s5_sensd_in;
         s5_tout_ff  <= s5_tout_in;
      end
      if (adv[6]) begin
         s6_plo_ff  <= s6_plo_in;
         s6_phi_ff  <= s6_phi_in;
         s6_offd_ff <= s5_offd_ff;
         s6_tout_ff <= s5_tout_ff;
      end
      if (adv[7]) begin
         s7_full_ff <= s7_full_in;
         s7_offd_ff <= s6_offd_ff;
         s7_tout_ff <= s6_tout_ff;
      end
      if (adv[8]) begin
         s8_rsp_ff <= s8_rsp_in;
      end
   end

   `BSC_ASSERT_NOW(a_full_blocks_req, rsp_valid && rsp_stall && (&vld_ff), req_stall, "full pipeline took a word")
   `BSC_ASSERT_NEXT(a_no_invented_rsp, !vld_ff[NStg-2] && adv[NStg-1], !rsp_valid, "result without a word")
   `BSC_ASSERT_NOW(a_cold_implies_low, vld_ff[3] && s3_cold_ff, s3_low_ff, "cold term outside low range")

endmodule
